[hw/rtl/lattice_radius_cell_walker_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the lattice radius cell walker
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef LATTICE_RADIUS_CELL_WALKER_CORE_MACROS_SVH
`define LATTICE_RADIUS_CELL_WALKER_CORE_MACROS_SVH

// Same-cycle implication.
`define LRCW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lrcw_pkg.sv]
// ----------------------------------------------------------------------------
// lrcw_pkg
// Shared widths, defaults, datapath operations and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lrcw_pkg;

  localparam int unsigned GRID_X_DEF   = 32;
  localparam int unsigned GRID_Y_DEF   = 32;
  localparam int unsigned GRID_Z_DEF   = 32;
  localparam int unsigned MAX_SPAN_DEF = 4;

  localparam int unsigned REG_W       = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_TUSER_W = 2;

  // Operation the controller asks of the datapath in a cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_ABS,
    OP_MUL,
    OP_FIN,
    OP_RES,
    OP_BOX1,
    OP_BOX2,
    OP_WRAP1,
    OP_WRAP2,
    OP_WRAP3,
    OP_EMIT_CELL,
    OP_EMIT_EMPTY
  } lrcw_op_e;

  typedef struct packed {
    lrcw_op_e   op;
    logic [2:0] bsel;   // bound number: axis in [2:1], upper side in [0]
  } lrcw_cmd_t;

  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic empty;        // box holds no cells
    logic walk_done;    // cursor sits on the final cell of the box
  } lrcw_status_t;

endpackage

`default_nettype wire

[hw/rtl/lrcw_ctrl.sv]
// ----------------------------------------------------------------------------
// lrcw_ctrl
// Sequencer: six bound evaluations, box clamp, coordinate wrap, cell walk or empty result.
// ----------------------------------------------------------------------------
`default_nettype none

module lrcw_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  lrcw_pkg::lrcw_status_t  status_i,
  output lrcw_pkg::lrcw_cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_ABS   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_FIN   = 4'd4;
  localparam logic [3:0] S_RES   = 4'd5;
  localparam logic [3:0] S_BOX1  = 4'd6;
  localparam logic [3:0] S_BOX2  = 4'd7;
  localparam logic [3:0] S_WRAP1 = 4'd8;
  localparam logic [3:0] S_WRAP2 = 4'd9;
  localparam logic [3:0] S_WRAP3 = 4'd10;
  localparam logic [3:0] S_WALK  = 4'd11;
  localparam logic [3:0] S_EMPTY = 4'd12;

  localparam logic [2:0] BOUND_LAST = 3'd5;

  logic [3:0] state_q, state_d;
  logic [2:0] bnd_q, bnd_d;

  always_comb begin
    state_d     = state_q;
    bnd_d       = bnd_q;
    in_ready_o  = 1'b0;
    cmd_o.op    = lrcw_pkg::OP_NONE;
    cmd_o.bsel  = bnd_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = lrcw_pkg::OP_LOAD;
          bnd_d    = 3'd0;
          state_d  = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.op = lrcw_pkg::OP_DIFF;
        state_d  = S_ABS;
      end
      S_ABS: begin
        cmd_o.op = lrcw_pkg::OP_ABS;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = lrcw_pkg::OP_MUL;
        state_d  = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = lrcw_pkg::OP_FIN;
        state_d  = S_RES;
      end
      S_RES: begin
        cmd_o.op = lrcw_pkg::OP_RES;
        if (bnd_q == BOUND_LAST) begin
          state_d = S_BOX1;
        end else begin
          bnd_d   = bnd_q + 3'd1;
          state_d = S_DIFF;
        end
      end
      S_BOX1: begin
        cmd_o.op = lrcw_pkg::OP_BOX1;
        state_d  = S_BOX2;
      end
      S_BOX2: begin
        cmd_o.op = lrcw_pkg::OP_BOX2;
        state_d  = status_i.empty ? S_EMPTY : S_WRAP1;
      end
      S_WRAP1: begin
        cmd_o.op = lrcw_pkg::OP_WRAP1;
        state_d  = S_WRAP2;
      end
      S_WRAP2: begin
        cmd_o.op = lrcw_pkg::OP_WRAP2;
        state_d  = S_WRAP3;
      end
      S_WRAP3: begin
        cmd_o.op = lrcw_pkg::OP_WRAP3;
        state_d  = S_WALK;
      end
      S_WALK: begin
        if (status_i.out_free) begin
          cmd_o.op = lrcw_pkg::OP_EMIT_CELL;
          if (status_i.walk_done) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.op = lrcw_pkg::OP_EMIT_EMPTY;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bnd_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      bnd_q   <= bnd_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lrcw_dp.sv]
// ----------------------------------------------------------------------------
// lrcw_dp
// Datapath: configuration registers, bound arithmetic on one shared
// multiplier, box clamp, periodic wrap, cell cursors and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrcw_dp #(
  parameter int unsigned GRID_X   = lrcw_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y   = lrcw_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z   = lrcw_pkg::GRID_Z_DEF,
  parameter int unsigned MAX_SPAN = lrcw_pkg::MAX_SPAN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lrcw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lrcw_pkg::REG_W-1:0]         cfg_wdata_i,
  input  logic [lrcw_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  lrcw_pkg::lrcw_cmd_t                cmd_i,
  output lrcw_pkg::lrcw_status_t             status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lrcw_pkg::OUT_TDATA_W-1:0]   out_data_o,
  output logic                               out_last_o,
  output logic [lrcw_pkg::OUT_TUSER_W-1:0]   out_user_o
);

  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [2:0] REG_INV_CELL_X = 3'd3;
  localparam logic [2:0] REG_INV_CELL_Y = 3'd4;
  localparam logic [2:0] REG_INV_CELL_Z = 3'd5;
  localparam logic [2:0] REG_PERIODIC   = 3'd6;

  localparam int unsigned GMAX_XY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int unsigned GMAX    = (GMAX_XY > GRID_Z) ? GMAX_XY : GRID_Z;
  localparam int unsigned W       = $clog2(GMAX);
  localparam int unsigned WP      = W + 1;

  localparam logic [14:0]        GX15    = 15'(GRID_X % 32768);
  localparam logic [14:0]        GXY15   = 15'((GRID_X * GRID_Y) % 32768);
  localparam logic signed [16:0] SPAN17  = 17'(MAX_SPAN);
  localparam logic [50:0]        HALF_M1 = 51'h7FFF_FFFF;
  localparam logic signed [18:0] Q_MIN   = -19'sd32768;
  localparam logic signed [18:0] Q_MAX   = 19'sd32767;
  localparam logic [31:0]        INV_RST = 32'h0001_0000;

  // Configuration
  logic signed [31:0] org_q [3];
  logic [31:0]        inv_q [3];
  logic               per_q;

  // Query and bound arithmetic
  logic signed [31:0] pt_q [3];
  logic [30:0]        rad_q;
  logic signed [33:0] dd_q, dd_d, pdiff;
  logic               neg_q, sat_q, sat_d;
  logic [33:0]        mag_q, mag_d;
  logic [63:0]        lp_q, lp_d;
  logic [34:0]        hp;
  logic [48:0]        pp_q, pp_d;
  logic signed [50:0] t_res;
  logic signed [18:0] q19;
  logic signed [15:0] bnd;
  logic [1:0]         ax;
  logic               side;

  // Box and walk
  logic signed [15:0] lo_q [3];
  logic signed [15:0] hi_q [3];
  logic               empty_q, trunc_q;
  logic signed [15:0] b1_lo [3];
  logic signed [15:0] b1_hi [3];
  logic [2:0]         b1_e;
  logic signed [15:0] b2_hi [3];
  logic [2:0]         b2_over;
  logic [33:0]        w1_prod [3];
  logic [33:0]        wprod_q [3];
  logic [W-1:0]       w2_rem [3];
  logic [W-1:0]       wrem_q [3];
  logic [W-1:0]       w3_adj [3];
  logic signed [15:0] c_q [3];
  logic signed [15:0] c_d [3];
  logic [W-1:0]       w_q [3];
  logic [W-1:0]       w_d [3];
  logic [W-1:0]       wlo_q [3];
  logic [W-1:0]       wlo_d [3];
  logic [W-1:0]       winc [3];
  logic [2:0]         endc;
  logic [14:0]        yoff_q, yoff_d, zoff_q, zoff_d;

  // Output register
  logic               out_valid_q;
  logic [14:0]        out_idx_q;
  logic [15:0]        out_cx_q, out_cy_q, out_cz_q;
  logic               out_last_q, out_empty_q, out_trunc_q;

  assign ax   = cmd_i.bsel[2:1];
  assign side = cmd_i.bsel[0];

  // Bound arithmetic: d = p - origin -/+ r, then ceil(d * inv - 0.5)
  always_comb begin
    pdiff = {{2{pt_q[ax][31]}}, pt_q[ax]} - {{2{org_q[ax][31]}}, org_q[ax]};
    dd_d  = side ? (pdiff + {3'd0, rad_q}) : (pdiff - {3'd0, rad_q});
    mag_d = dd_q[33] ? 34'(-dd_q) : 34'(dd_q);
    lp_d  = {32'd0, mag_q[31:0]} * {32'd0, inv_q[ax]};
    hp    = ({33'd0, mag_q[33:32]} * {3'd0, inv_q[ax]}) + {3'd0, lp_q[63:32]};
    sat_d = |hp[34:17];
    pp_d  = {hp[16:0], lp_q[31:0]};
    t_res = neg_q ? signed'(HALF_M1 - {2'd0, pp_q}) : signed'({2'd0, pp_q} + HALF_M1);
    q19   = t_res[50:32];
    if (sat_q) begin
      bnd = neg_q ? -16'sd32768 : 16'sd32767;
    end else if (q19 < Q_MIN) begin
      bnd = -16'sd32768;
    end else if (q19 > Q_MAX) begin
      bnd = 16'sd32767;
    end else begin
      bnd = q19[15:0];
    end
  end

  // Per-axis lanes: clamp, span cut, wrap of the lower bound, cursor step
  for (genvar a = 0; a < 3; a++) begin : g_lane
    localparam int unsigned GA  = (a == 0) ? GRID_X : ((a == 1) ? GRID_Y : GRID_Z);
    localparam int unsigned SH  = 16 + $clog2(GA);
    localparam longint unsigned RCP = ((64'd1 << SH) + 64'(GA) - 64'd1) / 64'(GA);
    localparam logic [17:0]        RCP18 = 18'(RCP);
    localparam logic [15:0]        G16   = 16'(GA);
    localparam logic signed [16:0] G17   = 17'(GA);
    localparam logic [WP-1:0]      GWP   = WP'(GA);
    localparam logic [WP-1:0]      C0    = WP'(32768 % GA);
    localparam logic [W-1:0]       GM1   = W'(GA - 1);

    logic signed [16:0] lo17, hi17, loc, hic, span;
    logic [15:0]        u, qv, qg, rem;
    logic [WP-1:0]      remx, adj;

    always_comb begin
      lo17 = {lo_q[a][15], lo_q[a]};
      hi17 = {hi_q[a][15], hi_q[a]};
      loc  = (!per_q && (lo17 < 17'sd0)) ? 17'sd0 : lo17;
      hic  = (!per_q && (hi17 > G17)) ? G17 : hi17;
      b1_lo[a] = loc[15:0];
      b1_hi[a] = hic[15:0];
      b1_e[a]  = (!per_q && ((loc > G17) || (hic < 17'sd0))) || (hic <= loc);

      span       = hi17 - lo17;
      b2_over[a] = !empty_q && (span > SPAN17);
      b2_hi[a]   = b2_over[a] ? 16'(lo17 + SPAN17) : hi_q[a];

      // Offset by 2^15 so the floor divide by the grid runs on unsigned values
      u          = {~lo_q[a][15], lo_q[a][14:0]};
      w1_prod[a] = {18'd0, u} * {16'd0, RCP18};
      qv         = 16'(wprod_q[a] >> SH);
      qg         = qv * G16;
      rem        = u - qg;
      w2_rem[a]  = rem[W-1:0];
      remx       = {1'b0, wrem_q[a]};
      adj        = (remx >= C0) ? (remx - C0) : (remx + GWP - C0);
      w3_adj[a]  = adj[W-1:0];

      endc[a] = 16'(c_q[a] + 16'sd1) == hi_q[a];
      winc[a] = (w_q[a] == GM1) ? '0 : (w_q[a] + 1'b1);
    end
  end

  // Cursor advance, x fastest
  always_comb begin
    c_d   = c_q;
    w_d   = w_q;
    wlo_d = wlo_q;
    case (cmd_i.op)
      lrcw_pkg::OP_BOX2: begin
        for (int i = 0; i < 3; i++) begin
          c_d[i] = lo_q[i];
        end
      end
      lrcw_pkg::OP_WRAP3: begin
        for (int i = 0; i < 3; i++) begin
          w_d[i]   = w3_adj[i];
          wlo_d[i] = w3_adj[i];
        end
      end
      lrcw_pkg::OP_EMIT_CELL: begin
        if (!endc[0]) begin
          c_d[0] = c_q[0] + 16'sd1;
          w_d[0] = winc[0];
        end else begin
          c_d[0] = lo_q[0];
          w_d[0] = wlo_q[0];
          if (!endc[1]) begin
            c_d[1] = c_q[1] + 16'sd1;
            w_d[1] = winc[1];
          end else begin
            c_d[1] = lo_q[1];
            w_d[1] = wlo_q[1];
            if (!endc[2]) begin
              c_d[2] = c_q[2] + 16'sd1;
              w_d[2] = winc[2];
            end else begin
              c_d[2] = lo_q[2];
              w_d[2] = wlo_q[2];
            end
          end
        end
      end
      default: begin
      end
    endcase
    yoff_d = 15'(w_d[1]) * GX15;
    zoff_d = 15'(w_d[2]) * GXY15;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        inv_q[i] <= INV_RST;
      end
      per_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X:   org_q[0] <= cfg_wdata_i;
        REG_ORIGIN_Y:   org_q[1] <= cfg_wdata_i;
        REG_ORIGIN_Z:   org_q[2] <= cfg_wdata_i;
        REG_INV_CELL_X: inv_q[0] <= cfg_wdata_i;
        REG_INV_CELL_Y: inv_q[1] <= cfg_wdata_i;
        REG_INV_CELL_Z: inv_q[2] <= cfg_wdata_i;
        REG_PERIODIC:   per_q    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    w_q    <= w_d;
    wlo_q  <= wlo_d;
    yoff_q <= yoff_d;
    zoff_q <= zoff_d;
    case (cmd_i.op)
      lrcw_pkg::OP_LOAD: begin
        pt_q[0] <= in_data_i[31:0];
        pt_q[1] <= in_data_i[63:32];
        pt_q[2] <= in_data_i[95:64];
        rad_q   <= in_data_i[126:96];
      end
      lrcw_pkg::OP_DIFF: dd_q <= dd_d;
      lrcw_pkg::OP_ABS: begin
        neg_q <= dd_q[33];
        mag_q <= mag_d;
      end
      lrcw_pkg::OP_MUL: lp_q <= lp_d;
      lrcw_pkg::OP_FIN: begin
        sat_q <= sat_d;
        pp_q  <= pp_d;
      end
      lrcw_pkg::OP_RES: begin
        if (side) begin
          hi_q[ax] <= bnd;
        end else begin
          lo_q[ax] <= bnd;
        end
      end
      lrcw_pkg::OP_BOX1: begin
        for (int i = 0; i < 3; i++) begin
          lo_q[i] <= b1_lo[i];
          hi_q[i] <= b1_hi[i];
        end
        empty_q <= |b1_e;
      end
      lrcw_pkg::OP_BOX2: begin
        for (int i = 0; i < 3; i++) begin
          hi_q[i] <= b2_hi[i];
        end
        trunc_q <= |b2_over;
      end
      lrcw_pkg::OP_WRAP1: begin
        for (int i = 0; i < 3; i++) begin
          wprod_q[i] <= w1_prod[i];
        end
      end
      lrcw_pkg::OP_WRAP2: begin
        for (int i = 0; i < 3; i++) begin
          wrem_q[i] <= w2_rem[i];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.op == lrcw_pkg::OP_EMIT_CELL) ||
                 (cmd_i.op == lrcw_pkg::OP_EMIT_EMPTY)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lrcw_pkg::OP_EMIT_CELL) begin
      out_idx_q   <= 15'(w_q[0]) + yoff_q + zoff_q;
      out_cx_q    <= c_q[0];
      out_cy_q    <= c_q[1];
      out_cz_q    <= c_q[2];
      out_last_q  <= &endc;
      out_empty_q <= 1'b0;
      out_trunc_q <= trunc_q;
    end else if (cmd_i.op == lrcw_pkg::OP_EMIT_EMPTY) begin
      out_idx_q   <= '0;
      out_cx_q    <= '0;
      out_cy_q    <= '0;
      out_cz_q    <= '0;
      out_last_q  <= 1'b1;
      out_empty_q <= 1'b1;
      out_trunc_q <= 1'b0;
    end
  end

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.empty     = empty_q;
  assign status_o.walk_done = &endc;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0, out_cz_q, out_cy_q, out_cx_q, out_idx_q};
  assign out_last_o  = out_last_q;
  assign out_user_o  = {out_trunc_q, out_empty_q};

endmodule

`default_nettype wire

[hw/rtl/lattice_radius_cell_walker_core.sv]
// Lattice radius cell walker. A query (point, cut radius; Q15.16 fixed point)
// arrives on the slave stream; for each axis the block works out the cell range
// [ceil((p-origin-r)*inv_cell-0.5), ceil((p-origin+r)*inv_cell-0.5)), clamps it
// to the grid in open mode or keeps it and wraps addresses in periodic mode,
// cuts any axis span to MAX_SPAN (flagging truncated), and then streams out
// every cell of the box, x fastest, with its flat address and unwrapped
// coordinates; tlast marks the final cell. An empty box gives one result with
// empty_res and tlast set and all else zero. The six box bounds share one
// 32 x 32 multiplier, each going through the diff, abs, mul, fin and res
// steps; clamping runs in BOX1 and BOX2, the periodic wrap of the start
// corner in WRAP1 to WRAP3, and the walk issues one cell a cycle into the
// output register while the master side does not stall. The slave side
// takes a new query only once the walk has finished; the last result may
// still wait in the output register. Configuration must be written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
// lattice_radius_cell_walker_core
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lattice_radius_cell_walker_core_macros.svh"

module lattice_radius_cell_walker_core #(
  parameter int unsigned GRID_X   = lrcw_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y   = lrcw_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z   = lrcw_pkg::GRID_Z_DEF,
  parameter int unsigned MAX_SPAN = lrcw_pkg::MAX_SPAN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Query stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64], radius [126:96], zero [127]
  input  logic [lrcw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Cell stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cell_index [14:0], cell_x [30:15], cell_y [46:31], cell_z [62:47], zero [63]
  output logic [lrcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast,
  // empty_res [0], truncated [1]
  output logic [lrcw_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  // Configuration writes
  input  logic                             cfg_we_i,
  input  logic [lrcw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lrcw_pkg::REG_W-1:0]       cfg_wdata_i
);

  lrcw_pkg::lrcw_cmd_t    cmd;
  lrcw_pkg::lrcw_status_t status;

  // Sequencer: owns the slave-side ready and steps the datapath
  lrcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: holds the query, the box and the output register
  lrcw_dp #(
    .GRID_X   (GRID_X),
    .GRID_Y   (GRID_Y),
    .GRID_Z   (GRID_Z),
    .MAX_SPAN (MAX_SPAN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

  // An empty box is a single zeroed, final, untruncated result
  `LRCW_ASSERT_IMPL(a_empty_shape, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == '0) && m_axis_tlast && !m_axis_tuser[1], "empty result not zeroed or not final")

  // Bound arithmetic follows every query transfer, so ready must drop
  `LRCW_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "query taken while bounds in progress")

  // Truncation is a per-query flag: hold it across the cells of one box
  `LRCW_ASSERT_IMPL(a_trunc_steady, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1 m_axis_tvalid, m_axis_tuser[1] == $past(m_axis_tuser[1]), "truncated flag changed within a box")

endmodule

`default_nettype wire
